// ===== design/b64e_pkg.sv =====
// Package for the base64 stream encoder: payload structs, queue entry type,
// group phase codes and the sextet-to-character table.
// No dependencies.
`default_nettype none

package b64e_pkg;

  localparam int unsigned B64E_QUEUE_DEPTH = 2;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       final_char;
  } out_item_t;

  // One queue entry: the characters caused by one byte.
  typedef struct packed {
    logic [3:0][6:0] chars;
    logic [1:0]      last_idx;
    logic            fin;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    PhFirst  = 3'b001,
    PhSecond = 3'b010,
    PhThird  = 3'b100
  } phase_e;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/base64_stream_encoder_unit.sv =====
// Channel | dir | handshake                  | payload
// input   | in  | in_valid_i / in_stall_o    | in_item_i  (data_byte, final_byte)
// output  | out | out_valid_o / out_stall_i  | out_item_o (out_char, final_char)
//
// A byte is taken in any cycle the queue has room and yields one to four
// characters; the output register sends one character per cycle unless
// out_stall_i holds it. An accepted byte goes through the queue and then
// the output register before its first character appears.
// Reset clears phase, queue pointers and output valid. An output stall holds
// the output register; the queue absorbs bytes until it fills.
// Top level of the base64 stream encoder; instantiates front, queue, back.
// Uses b64e_pkg.
`default_nettype none

module base64_stream_encoder_unit import b64e_pkg::*; #(
  parameter int unsigned QueueDepth = B64E_QUEUE_DEPTH
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire           out_stall_i,
  output out_item_t     out_item_o
);

  q_status_t q_status;
  cmd_t      cmd;
  cmd_t      head;
  logic      push;
  logic      pop;

  assign in_stall_o = q_status.full;

  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_accept_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> push)
    else $error("accepted byte not queued");

  a_pop_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("group retired without output");
`endif

endmodule

`default_nettype wire

// ===== design/b64e_front.sv =====
// Front end: accepts bytes, tracks the group phase and leftover bits and
// builds one queue entry of one to four characters per byte. Uses b64e_pkg.
`default_nettype none

module b64e_front import b64e_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  input  wire in_item_t  in_item_i,
  input  wire q_status_t q_status_i,
  output logic           push_o,
  output cmd_t           cmd_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic [7:0] b;
  logic       fin;

  assign b      = in_item_i.data_byte;
  assign fin    = in_item_i.final_byte;
  assign push_o = in_valid_i && !q_status_i.full;

  always_comb begin
    phase_d        = phase_q;
    left_d         = left_q;
    cmd_o.chars    = {4{PAD_CHAR}};
    cmd_o.last_idx = 2'd0;
    cmd_o.fin      = fin;
    case (phase_q)
      PhSecond: begin
        cmd_o.chars[0] = sextet_char({left_q[1:0], b[7:4]});
        if (fin) begin
          cmd_o.chars[1] = sextet_char({b[3:0], 2'b00});
          cmd_o.last_idx = 2'd2;
          phase_d        = PhFirst;
          left_d         = 4'd0;
        end else begin
          phase_d = PhThird;
          left_d  = b[3:0];
        end
      end
      PhThird: begin
        cmd_o.chars[0] = sextet_char({left_q, b[7:6]});
        cmd_o.chars[1] = sextet_char(b[5:0]);
        cmd_o.last_idx = 2'd1;
        phase_d        = PhFirst;
        left_d         = 4'd0;
      end
      default: begin
        cmd_o.chars[0] = sextet_char(b[7:2]);
        if (fin) begin
          cmd_o.chars[1] = sextet_char({b[1:0], 4'b0000});
          cmd_o.last_idx = 2'd3;
          phase_d        = PhFirst;
          left_d         = 4'd0;
        end else begin
          phase_d = PhSecond;
          left_d  = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      left_q  <= 4'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/b64e_queue.sv =====
// Short queue of character groups between front and back end.
// Uses b64e_pkg for the entry and status types.
`default_nettype none

module b64e_queue import b64e_pkg::*; #(
  parameter int unsigned Depth = B64E_QUEUE_DEPTH
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push_i,
  input  wire cmd_t  cmd_i,
  input  wire        pop_i,
  output cmd_t       head_o,
  output q_status_t  status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/b64e_back.sv =====
// Back end: walks the characters of the queue head, one per cycle while the
// output is not stalled, into the output register. Uses b64e_pkg.
`default_nettype none

module b64e_back import b64e_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire cmd_t      head_i,
  input  wire q_status_t q_status_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output out_item_t      out_item_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       load;
  logic       at_last;

  assign load        = !out_valid_q || !out_stall_i;
  assign at_last     = (idx_q == head_i.last_idx);
  assign pop_o       = load && !q_status_i.empty && at_last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load && !q_status_i.empty) begin
      out_q.out_char   <= head_i.chars[idx_q];
      out_q.final_char <= head_i.fin && at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (load) begin
      out_valid_q <= !q_status_i.empty;
      if (!q_status_i.empty) begin
        // advance within the group, rewind once the last one goes out
        idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire
